/* design/sksis_pkg.sv */
`default_nettype none

package sksis_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int KEY_W = 16;

  localparam logic [1:0] KEY_ARRIVAL  = 2'd0;
  localparam logic [1:0] KEY_PRIORITY = 2'd1;
  localparam logic [1:0] KEY_SERVICE  = 2'd2;
  localparam logic [1:0] KEY_DEADLINE = 2'd3;

  typedef struct packed {
    logic [7:0]  job_id;
    logic [7:0]  priority_req;
    logic [15:0] service_time;
    logic [15:0] deadline;
    logic        last_entry;
  } job_t;

  typedef struct packed {
    logic [7:0]  out_job_id;
    logic [7:0]  out_priority;
    logic [15:0] out_service_time;
    logic [15:0] out_deadline;
    logic        out_last;
    logic        overflowed;
  } result_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  pri;
    logic [15:0] svc;
    logic [15:0] dl;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic ins;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic one_left;
  } ctrl_status_t;

  function automatic logic [KEY_W-1:0] key_of(input logic [1:0] sel,
                                              input logic [7:0] pri,
                                              input logic [15:0] svc,
                                              input logic [15:0] dl);
    logic [KEY_W-1:0] k;
    case (sel)
      KEY_PRIORITY: k = {8'd0, pri};
      KEY_SERVICE:  k = svc;
      KEY_DEADLINE: k = dl;
      default:      k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/stable_key_select_insertion_sorter_unit.sv */
// Stable insertion sorter for job entries. A job word is taken at a clock
// edge where start is high and busy is low, and is placed into a chain of
// DEPTH compare-and-shift cells in that same cycle, so words that do not
// end a set are taken one per cycle. When the word marked last_entry is
// taken, busy rises and the N stored entries leave in sorted order on
// consecutive cycles, the first result_valid strobe following once the
// controller has entered ST_EMIT and result_valid has been registered; busy
// stays high while entries are emitted. Results cannot be stalled: each
// result_valid strobe is high for a single cycle. Words beyond DEPTH are
// dropped and every result of that set shows overflowed. The sort key is
// written through the cfg channel, which is always ready; the user must write
// it only while the block is idle, as the block itself does not enforce this.
`default_nettype none

module stable_key_select_insertion_sorter_unit
  import sksis_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data,
  input  wire logic       start,
  output logic            busy,
  input  wire job_t       job_in,
  output result_t         result,
  output logic            result_valid
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  sksis_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_entry (job_in.last_entry),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  sksis_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .job_in       (job_in),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire

/* design/sksis_ctrl.sv */
`default_nettype none

module sksis_ctrl
  import sksis_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         last_entry,
  input  wire ctrl_status_t status,
  output ctrl_cmd_t         cmd,
  output logic              busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.ins = 1'b1;
          if (last_entry) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        busy = 1'b1;
        cmd.emit = 1'b1;
        if (status.one_left) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/sksis_datapath.sv */
`default_nettype none

module sksis_datapath
  import sksis_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_data,
  input  wire job_t         job_in,
  input  wire ctrl_cmd_t    cmd,
  output ctrl_status_t      status,
  output result_t           result,
  output logic              result_valid
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]       sort_key;
  entry_t           cells [DEPTH];
  logic [CW-1:0]    count;
  logic             drop_flag;
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] prev_gt;
  logic [KEY_W-1:0] new_key;
  logic             has_room;
  entry_t           new_entry;

  always_comb begin
    new_key = key_of(sort_key, job_in.priority_req, job_in.service_time, job_in.deadline);
    has_room = count < CW'(DEPTH);
    new_entry.id = job_in.job_id;
    new_entry.pri = job_in.priority_req;
    new_entry.svc = job_in.service_time;
    new_entry.dl = job_in.deadline;
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (sort_key != KEY_ARRIVAL) && (CW'(i) < count) &&
              (key_of(sort_key, cells[i].pri, cells[i].svc, cells[i].dl) > new_key);
    end
    prev_gt = {gt[DEPTH-2:0], 1'b0};
    status.one_left = count == CW'(1);
  end

  // Cells take left neighbor or new word, right neighbor on emit, or hold.
  always_ff @(posedge clk) begin
    if (cmd.ins && has_room) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (prev_gt[i]) begin
          cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || (CW'(i) == count)) begin
          cells[i] <= new_entry;
        end
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        cells[i] <= cells[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key <= KEY_ARRIVAL;
      count <= '0;
      drop_flag <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        sort_key <= cfg_data;
      end
      result_valid <= cmd.emit;
      if (cmd.ins) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          drop_flag <= 1'b1;
        end
      end else if (cmd.emit) begin
        count <= count - CW'(1);
        if (status.one_left) begin
          drop_flag <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out_job_id <= cells[0].id;
      result.out_priority <= cells[0].pri;
      result.out_service_time <= cells[0].svc;
      result.out_deadline <= cells[0].dl;
      result.out_last <= status.one_left;
      result.overflowed <= drop_flag;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds store depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> count != '0)
    else $error("emission from an empty store");

  a_strobe_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.emit))
    else $error("result strobe without an emission step");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.out_last) |-> (count == '0 && !drop_flag))
    else $error("store not empty after the final result");

endmodule

`default_nettype wire
